### hw/rtl/fba_pkg.sv
// fba_pkg: constants, command codes, bitmap port struct and word helper functions
// shared by the frame bitmap allocator top level and its bitmap store
// no dependencies
package fba_pkg;

    // memory geometry
    localparam int FRAMES      = 8192;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORDS       = FRAMES / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    // byte address of memory end needs one bit above the last byte
    localparam int MEM_W       = FRAME_W + FRAME_SHIFT + 1;
    localparam longint unsigned MEM_BYTES = longint'(FRAMES) * longint'(FRAME_BYTES);

    // field widths
    localparam int FUNC_W = 3;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 14;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC       = 3'd0,
        FN_FREE_FRAME  = 3'd1,
        FN_REGION_FREE = 3'd2,
        FN_REGION_USED = 3'd3,
        FN_REINIT      = 3'd4
    } func_t;

    // bitmap access request: read, write and clear controls
    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clear;
    } map_req_t;

    // population count of one bitmap word, five adder levels
    function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] c1;
        logic [WORD_BITS-1:0] c2;
        logic [WORD_BITS-1:0] c4;
        logic [WORD_BITS-1:0] c8;
        logic [WORD_BITS-1:0] c16;
        c1  = (w  & 32'h5555_5555) + ((w  >> 1)  & 32'h5555_5555);
        c2  = (c1 & 32'h3333_3333) + ((c1 >> 2)  & 32'h3333_3333);
        c4  = (c2 & 32'h0F0F_0F0F) + ((c2 >> 4)  & 32'h0F0F_0F0F);
        c8  = (c4 & 32'h00FF_00FF) + ((c4 >> 8)  & 32'h00FF_00FF);
        c16 = (c8 & 32'h0000_FFFF) + ((c8 >> 16) & 32'h0000_FFFF);
        return c16[BIT_W:0];
    endfunction

    // index of the lowest clear bit, zero when none is clear
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### hw/rtl/fba_bitmap.sv
// fba_bitmap: used-frame bitmap store, one word per address, registered read
// per-word valid bits give the all-used state at reset and on clear
// depends on fba_pkg
module fba_bitmap (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fba_pkg::map_req_t             req,
    output logic [fba_pkg::WORD_BITS-1:0] rd_word
);

    logic [fba_pkg::WORD_BITS-1:0] mem [fba_pkg::WORDS];
    logic [fba_pkg::WORD_BITS-1:0] rd_data_reg;
    logic [fba_pkg::WORDS-1:0]     valid_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // a word never written since clear reads as all used
    assign rd_word = rd_valid_reg ? rd_data_reg : '1;

endmodule

### hw/rtl/frame_bitmap_allocator.sv
// frame_bitmap_allocator: first-fit physical frame allocator over a used-frame bitmap
// top level: command sequencer, per-word mask unit and used-frame counter
// depends on fba_pkg and fba_bitmap
// usage
//   slave channel s_*: one command transaction, tdata = func, base_addr, region_len
//   master channel m_*: one result per command, tdata = frame_addr, found,
//   used_count, free_count
//   commands: allocate, free frame, free region (shrunk to frames), mark region used, reinit
// timing
//   a command walks n bitmap words, one word per cycle through the single
//   read-modify-write word unit; n is 1 for a frame free inside memory, up to 256 for an
//   allocate scan or a region, 0 for reinit and ignored commands
//   each command passes setup, prime, the walk and the final state, which waits for
//   a free output register; the result then registers and s_tready rises with it
// reset
//   synchronous, active low: every frame used, count at full, no result pending;
//   the bitmap needs no clearing pass, per-word valid bits reset at once
// back-pressure
//   the result sits in an output register; a new command may be accepted while
//   it waits, and the next result holds in its final state until it is taken
module frame_bitmap_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[2:0], base_addr[34:3], region_len[66:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // frame_addr[31:0], found[32], used_count[46:33],
                                   // free_count[60:47], zero fill
);

    localparam int SF_W  = fba_pkg::ADDR_W + 1 - fba_pkg::FRAME_SHIFT;
    localparam int EF_W  = fba_pkg::FRAME_W + 1;
    localparam int OUT_W = fba_pkg::ADDR_W + 1 + 2 * fba_pkg::CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_PRIME = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // command transaction
    logic [fba_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [fba_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [fba_pkg::ADDR_W-1:0] len_reg, len_next;

    // range of frames to walk
    logic [SF_W-1:0]             start_reg, start_next;
    logic [fba_pkg::MEM_W-1:0]   end_reg, end_next;
    logic [fba_pkg::FRAME_W-1:0] first_frame_reg, first_frame_next;
    logic [fba_pkg::FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic [fba_pkg::WORD_AW-1:0] word_reg, word_next;
    logic                        alloc_reg, alloc_next;
    logic                        mark_used_reg, mark_used_next;

    // bits changed by the last word, counted in the cycle after
    logic [fba_pkg::WORD_BITS-1:0] chg_reg, chg_next;
    logic                          chg_up_reg, chg_up_next;
    logic [fba_pkg::CNT_W-1:0]     used_total_reg, used_total_next;

    // per-command result
    logic [fba_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic                       res_found_reg, res_found_next;

    // output register
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]           out_reg, out_next;

    fba_pkg::map_req_t             mreq;
    logic [fba_pkg::WORD_BITS-1:0] rd_word;

    fba_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rd_word (rd_word)
    );

    // setup arithmetic
    logic [fba_pkg::ADDR_W:0]   sum_end;
    logic [fba_pkg::ADDR_W:0]   sum_up;
    // prime arithmetic
    logic [fba_pkg::MEM_W-1:0]  end_up;
    logic [EF_W-1:0]            ef;
    logic [EF_W-1:0]            ef_less;
    logic [EF_W-1:0]            sf_short;
    logic                       in_range;
    logic                       walk_ok;
    // word unit
    logic [fba_pkg::BIT_W-1:0]     lo_bit;
    logic [fba_pkg::BIT_W-1:0]     hi_bit;
    logic [fba_pkg::WORD_BITS-1:0] mask;
    logic [fba_pkg::BIT_W-1:0]     zero_bit;
    logic [fba_pkg::WORD_BITS-1:0] zero_onehot;
    logic                          last_word;
    // counter and output
    logic [fba_pkg::BIT_W:0]       chg_pop;
    logic [fba_pkg::CNT_W-1:0]     used_upd;
    logic                          out_free;
    logic [fba_pkg::CNT_W-1:0]     free_cnt;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(64 - OUT_W){1'b0}}, out_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // region end clipped to memory size, start rounded up for a region free
    assign sum_end = {1'b0, base_reg} + {1'b0, len_reg};
    assign sum_up  = {1'b0, base_reg} + (fba_pkg::ADDR_W + 1)'(fba_pkg::FRAME_BYTES - 1);

    // end frame and range checks
    assign end_up   = end_reg + fba_pkg::MEM_W'(fba_pkg::FRAME_BYTES - 1);
    assign in_range = start_reg < SF_W'(fba_pkg::FRAMES);
    assign sf_short = {1'b0, start_reg[fba_pkg::FRAME_W-1:0]};
    assign ef_less  = ef - EF_W'(1);
    assign walk_ok  = in_range && (ef > sf_short);

    always_comb begin
        unique case (fba_pkg::func_t'(func_reg))
            fba_pkg::FN_REGION_FREE: ef = end_reg[fba_pkg::MEM_W-1:fba_pkg::FRAME_SHIFT];
            fba_pkg::FN_REGION_USED: ef = end_up[fba_pkg::MEM_W-1:fba_pkg::FRAME_SHIFT];
            default:                 ef = sf_short + EF_W'(1);
        endcase
    end

    // mask of the frames of the current word that lie in the range
    assign lo_bit = (word_reg == first_frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_W])
                    ? first_frame_reg[fba_pkg::BIT_W-1:0] : '0;
    assign hi_bit = (word_reg == last_frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_W])
                    ? last_frame_reg[fba_pkg::BIT_W-1:0] : '1;
    assign mask   = ({fba_pkg::WORD_BITS{1'b1}} << lo_bit)
                  & ({fba_pkg::WORD_BITS{1'b1}} >> (~hi_bit));
    assign last_word   = (word_reg == last_frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]);
    assign zero_bit    = fba_pkg::lowest_zero(rd_word);
    assign zero_onehot = fba_pkg::WORD_BITS'(1) << zero_bit;

    // used counter absorbs the previous word's changes
    assign chg_pop  = fba_pkg::popcount(chg_reg);
    assign used_upd = chg_up_reg ? used_total_reg + fba_pkg::CNT_W'(chg_pop)
                                 : used_total_reg - fba_pkg::CNT_W'(chg_pop);
    assign free_cnt = fba_pkg::CNT_W'(fba_pkg::FRAMES) - used_total_next;

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        base_next        = base_reg;
        len_next         = len_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        first_frame_next = first_frame_reg;
        last_frame_next  = last_frame_reg;
        word_next        = word_reg;
        alloc_next       = alloc_reg;
        mark_used_next   = mark_used_reg;
        chg_next         = '0;
        chg_up_next      = chg_up_reg;
        used_total_next  = used_upd;
        res_addr_next    = res_addr_reg;
        res_found_next   = res_found_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_next         = out_reg;
        mreq             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tdata[fba_pkg::FUNC_W-1:0];
                    base_next  = s_tdata[fba_pkg::FUNC_W +: fba_pkg::ADDR_W];
                    len_next   = s_tdata[fba_pkg::FUNC_W + fba_pkg::ADDR_W +: fba_pkg::ADDR_W];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sum_end > (fba_pkg::ADDR_W + 1)'(fba_pkg::MEM_BYTES)) begin
                    end_next = fba_pkg::MEM_W'(fba_pkg::MEM_BYTES);
                end else begin
                    end_next = sum_end[fba_pkg::MEM_W-1:0];
                end
                if (fba_pkg::func_t'(func_reg) == fba_pkg::FN_REGION_FREE) begin
                    start_next = sum_up[fba_pkg::ADDR_W:fba_pkg::FRAME_SHIFT];
                end else begin
                    start_next = {1'b0, base_reg[fba_pkg::ADDR_W-1:fba_pkg::FRAME_SHIFT]};
                end
                state_next = ST_PRIME;
            end
            ST_PRIME: begin
                res_addr_next    = '0;
                res_found_next   = 1'b0;
                first_frame_next = start_reg[fba_pkg::FRAME_W-1:0];
                last_frame_next  = ef_less[fba_pkg::FRAME_W-1:0];
                alloc_next       = 1'b0;
                mark_used_next   = 1'b0;
                state_next       = ST_FIN;
                unique case (fba_pkg::func_t'(func_reg))
                    fba_pkg::FN_ALLOC: begin
                        first_frame_next = '0;
                        last_frame_next  = fba_pkg::FRAME_W'(fba_pkg::FRAMES - 1);
                        alloc_next       = 1'b1;
                        state_next       = ST_RUN;
                    end
                    fba_pkg::FN_FREE_FRAME, fba_pkg::FN_REGION_FREE: begin
                        if (walk_ok && (len_reg != '0 ||
                            fba_pkg::func_t'(func_reg) == fba_pkg::FN_FREE_FRAME)) begin
                            state_next = ST_RUN;
                        end
                    end
                    fba_pkg::FN_REGION_USED: begin
                        mark_used_next = 1'b1;
                        if (walk_ok && len_reg != '0) begin
                            state_next = ST_RUN;
                        end
                    end
                    fba_pkg::FN_REINIT: begin
                        mreq.clear      = 1'b1;
                        used_total_next = fba_pkg::CNT_W'(fba_pkg::FRAMES);
                    end
                    default: begin
                    end
                endcase
                // prefetch the first word of the walk
                word_next    = first_frame_next[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
                mreq.rd_en   = (state_next == ST_RUN);
                mreq.rd_addr = word_next;
            end
            ST_RUN: begin
                mreq.wr_addr = word_reg;
                if (alloc_reg) begin
                    chg_up_next = 1'b1;
                    if (rd_word != '1) begin
                        mreq.wr_en     = 1'b1;
                        mreq.wr_data   = rd_word | zero_onehot;
                        chg_next       = zero_onehot;
                        res_found_next = 1'b1;
                        res_addr_next  = fba_pkg::ADDR_W'({word_reg, zero_bit})
                                         << fba_pkg::FRAME_SHIFT;
                    end
                end else begin
                    chg_up_next  = mark_used_reg;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_data = mark_used_reg ? (rd_word | mask) : (rd_word & ~mask);
                    chg_next     = mark_used_reg ? (mask & ~rd_word) : (mask & rd_word);
                end
                if (last_word || (alloc_reg && rd_word != '1)) begin
                    state_next = ST_FIN;
                end else begin
                    word_next    = word_reg + fba_pkg::WORD_AW'(1);
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = word_next;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_next      = {free_cnt, used_total_next, res_found_reg, res_addr_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_total_reg <= fba_pkg::CNT_W'(fba_pkg::FRAMES);
            chg_reg        <= '0;
            chg_up_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_total_reg <= used_total_next;
            chg_reg        <= chg_next;
            chg_up_reg     <= chg_up_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        base_reg        <= base_next;
        len_reg         <= len_next;
        start_reg       <= start_next;
        end_reg         <= end_next;
        first_frame_reg <= first_frame_next;
        last_frame_reg  <= last_frame_next;
        word_reg        <= word_next;
        alloc_reg       <= alloc_next;
        mark_used_reg   <= mark_used_next;
        res_addr_reg    <= res_addr_next;
        res_found_reg   <= res_found_next;
        out_reg         <= out_next;
    end

    // the used count never exceeds the number of frames
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_total_reg <= fba_pkg::CNT_W'(fba_pkg::FRAMES))
        else $error("used frame count above frame total");

    // a result without a found frame carries address zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[32]) |-> (m_tdata[31:0] == '0))
        else $error("frame address set without found");

    // used and free counts of a result add up to the frame total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[46:33] + m_tdata[60:47] == fba_pkg::CNT_W'(fba_pkg::FRAMES)))
        else $error("used and free counts inconsistent");

    // the bitmap is only written during a walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.wr_en |-> (state_reg == ST_RUN))
        else $error("bitmap write outside walk");

    // a result leaving the final state returns the sequencer to idle with a result pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (state_reg == ST_IDLE && m_tvalid))
        else $error("result not presented after final state");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for frame_bitmap_allocator, directed then random commands
// depends on fba_pkg for geometry constants and command codes, and on the allocator rtl
module tb_top;

    // codes the block does not decode, answered with counts only
    localparam logic [fba_pkg::FUNC_W-1:0] FN_FIRST_UNKNOWN = 3'd5;
    localparam logic [fba_pkg::FUNC_W-1:0] FN_LAST_UNKNOWN  = 3'd7;

    localparam longint unsigned ADDR_MAX    = 64'hFFFF_FFFF;
    localparam int unsigned     MEM_TOP     = 32'(fba_pkg::MEM_BYTES - 1);
    localparam int              RANDOM_CMDS = 1925;
    // watchdog limit, meant to leave plenty of margin over a correct run
    localparam int              CYCLE_LIMIT = 3_000_000;
    // a command walks at most 256 words plus its setup, prime and final states
    localparam int              DRAIN_CYCLES = 300;

    // command transaction, func in the lowest bits as on s_tdata
    typedef struct packed {
        logic [fba_pkg::ADDR_W-1:0] region_len;
        logic [fba_pkg::ADDR_W-1:0] base_addr;
        logic [fba_pkg::FUNC_W-1:0] func;
    } cmd_t;

    // result transaction, frame_addr in the lowest bits as on m_tdata
    typedef struct packed {
        logic [fba_pkg::CNT_W-1:0]  free_count;
        logic [fba_pkg::CNT_W-1:0]  used_count;
        logic                       found;
        logic [fba_pkg::ADDR_W-1:0] frame_addr;
    } result_t;

    // mirror of the frame bitmap and the queue of results it predicts
    class alloc_scoreboard;
        bit [fba_pkg::FRAMES-1:0] frame_used;
        int unsigned              used_total;
        result_t                  pending[$];
        int                       errors;

        function new();
            frame_used = '1;
            used_total = fba_pkg::FRAMES;
            errors     = 0;
        endfunction

        // end of a byte region, clipped to memory size
        function longint unsigned clip_end(longint unsigned base, longint unsigned len);
            longint unsigned e;
            e = base + len;
            if (e > ADDR_MAX) begin
                e = fba_pkg::MEM_BYTES;
            end
            if (e > fba_pkg::MEM_BYTES) begin
                e = fba_pkg::MEM_BYTES;
            end
            return e;
        endfunction

        function void mark_frames(longint unsigned first, longint unsigned last, bit to_used);
            if (last > fba_pkg::FRAMES) begin
                last = fba_pkg::FRAMES;
            end
            for (longint unsigned f = first; f < last; f++) begin
                if (frame_used[f] != to_used) begin
                    frame_used[f] = to_used;
                    if (to_used) begin
                        used_total++;
                    end else if (used_total > 0) begin
                        used_total--;
                    end
                end
            end
        endfunction

        // apply one accepted command to the mirror and queue the result it must give
        function void note_command(cmd_t c);
            result_t         r;
            longint unsigned base;
            longint unsigned len;
            longint unsigned fb;
            longint unsigned e;
            longint unsigned sf;
            longint unsigned ef;
            r    = '0;
            base = c.base_addr;
            len  = c.region_len;
            fb   = fba_pkg::FRAME_BYTES;
            case (c.func)
                fba_pkg::FN_ALLOC: begin
                    // first fit from frame zero upwards
                    for (int f = 0; f < fba_pkg::FRAMES; f++) begin
                        if (!frame_used[f]) begin
                            frame_used[f] = 1'b1;
                            used_total++;
                            r.frame_addr = 32'(f * fba_pkg::FRAME_BYTES);
                            r.found      = 1'b1;
                            break;
                        end
                    end
                end
                fba_pkg::FN_FREE_FRAME: begin
                    sf = base / fb;
                    if (sf < fba_pkg::FRAMES) begin
                        mark_frames(sf, sf + 1, 1'b0);
                    end
                end
                fba_pkg::FN_REGION_FREE: begin
                    // shrink to whole frames
                    if (len != 0) begin
                        e  = clip_end(base, len);
                        sf = (base + fb - 1) / fb;
                        ef = e / fb;
                        if (sf * fb < fba_pkg::MEM_BYTES && ef > sf) begin
                            mark_frames(sf, ef, 1'b0);
                        end
                    end
                end
                fba_pkg::FN_REGION_USED: begin
                    // grow to whole frames
                    if (len != 0) begin
                        e  = clip_end(base, len);
                        sf = base / fb;
                        ef = (e + fb - 1) / fb;
                        if (sf * fb < fba_pkg::MEM_BYTES) begin
                            mark_frames(sf, ef, 1'b1);
                        end
                    end
                end
                fba_pkg::FN_REINIT: begin
                    frame_used = '1;
                    used_total = fba_pkg::FRAMES;
                end
                default: begin
                end
            endcase
            r.used_count = fba_pkg::CNT_W'(used_total);
            r.free_count = fba_pkg::CNT_W'(fba_pkg::FRAMES - used_total);
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.frame_addr !== want.frame_addr) begin
                $error("frame_addr: expected %h, got %h", want.frame_addr, got.frame_addr);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %b, got %b", want.found, got.found);
                errors++;
            end
            if (got.used_count !== want.used_count) begin
                $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // func[2:0], base_addr[34:3], region_len[66:35], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // frame_addr[31:0], found[32], used_count[46:33],
                            // free_count[60:47], zero fill

    alloc_scoreboard sb;
    int              cmds_sent;
    bit              cmd_quiet;

    frame_bitmap_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cmd_t make_cmd(logic [fba_pkg::FUNC_W-1:0] f,
                                      logic [fba_pkg::ADDR_W-1:0] b,
                                      logic [fba_pkg::ADDR_W-1:0] l);
        cmd_t c;
        c.func       = f;
        c.base_addr  = b;
        c.region_len = l;
        return c;
    endfunction

    // region length: mostly a few dozen frames, sometimes empty, huge or arbitrary
    function automatic logic [fba_pkg::ADDR_W-1:0] random_len();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return $urandom;
        end else if (pick == 2) begin
            return $urandom_range(1, MEM_TOP + 1);
        end
        return $urandom_range(1, 48 * fba_pkg::FRAME_BYTES);
    endfunction

    // region base: mostly inside memory, now and then anywhere in the address space
    function automatic logic [fba_pkg::ADDR_W-1:0] random_base();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, MEM_TOP);
    endfunction

    function automatic cmd_t random_cmd();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            return make_cmd(fba_pkg::FN_ALLOC, $urandom, $urandom);
        end else if (pick < 50) begin
            return make_cmd(fba_pkg::FN_FREE_FRAME, random_base(), $urandom);
        end else if (pick < 70) begin
            return make_cmd(fba_pkg::FN_REGION_FREE, random_base(), random_len());
        end else if (pick < 88) begin
            return make_cmd(fba_pkg::FN_REGION_USED, random_base(), random_len());
        end else if (pick < 91) begin
            return make_cmd(fba_pkg::FN_REINIT, $urandom, $urandom);
        end else if (pick < 94) begin
            return make_cmd(fba_pkg::FUNC_W'($urandom_range(FN_FIRST_UNKNOWN, FN_LAST_UNKNOWN)),
                            $urandom, $urandom);
        end
        // raw noise over every field
        return make_cmd(fba_pkg::FUNC_W'($urandom_range(0, 7)), $urandom, $urandom);
    endfunction

    // one command transaction; entered and left at a falling edge
    task automatic drive_command(cmd_t c);
        int gap;
        // every 40 transactions, choose anew between back-to-back and randomly gapped stretches
        if (cmds_sent % 40 == 0) begin
            cmd_quiet = ($urandom_range(0, 3) == 0);
        end
        gap = cmd_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, c};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
        cmds_sent++;
        @(negedge aclk);
    endtask

    // result side: random back-pressure, every accepted result checked
    initial begin
        int gap;
        int taken;
        bit quiet;
        taken    = 0;
        quiet    = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken % 40 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(result_t'(m_tdata[60:0]));
            taken++;
            @(negedge aclk);
        end
    end

    // watchdog against a hung handshake
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        sb        = new();
        cmds_sent = 0;
        cmd_quiet = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, starting from the all-used reset state
        drive_command(make_cmd(fba_pkg::FN_ALLOC, 32'h0, 32'h0));               // nothing free
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'h0000_2000, 32'h0)); // empty region
        drive_command(make_cmd(fba_pkg::FN_REGION_USED, 32'h0000_2000, 32'h0));
        drive_command(make_cmd(fba_pkg::FN_FREE_FRAME, 32'h0200_0000, 32'h0));  // past memory
        drive_command(make_cmd(fba_pkg::FN_FREE_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // frames 1 to 3
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'h0000_0001, 32'h0000_3FFF));
        // rounds to nothing
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'h0000_1001, 32'h0000_1000));
        // wraps, no start
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'hFFFF_F000, 32'h0000_2000));
        drive_command(make_cmd(fba_pkg::FN_ALLOC, 32'h0, 32'h0));               // lowest is frame 1
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'h0, 32'hFFFF_FFFF)); // whole memory
        drive_command(make_cmd(fba_pkg::FN_ALLOC, 32'h0, 32'h0));               // frame zero, found
        drive_command(make_cmd(fba_pkg::FN_FREE_FRAME, 32'h0000_0FFF, 32'h0));
        drive_command(make_cmd(fba_pkg::FN_FREE_FRAME, 32'h0000_0FFF, 32'h0));  // already free
        // grows to frame 1
        drive_command(make_cmd(fba_pkg::FN_REGION_USED, 32'h0000_1800, 32'h0000_0001));
        // end clipped
        drive_command(make_cmd(fba_pkg::FN_REGION_USED, 32'h01FF_F000, 32'hFFFF_FFFF));
        // start past memory
        drive_command(make_cmd(fba_pkg::FN_REGION_USED, 32'h0200_0000, 32'h0000_0005));
        drive_command(make_cmd(fba_pkg::FN_REGION_USED, 32'h0, 32'h0200_0000)); // all used
        drive_command(make_cmd(fba_pkg::FN_FREE_FRAME, 32'h01FF_FABC, 32'h0));  // last frame
        drive_command(make_cmd(fba_pkg::FN_ALLOC, 32'h0, 32'h0));               // full scan to the top
        drive_command(make_cmd(fba_pkg::FN_ALLOC, 32'h0, 32'h0));               // full again
        for (int u = FN_FIRST_UNKNOWN; u <= FN_LAST_UNKNOWN; u++) begin
            drive_command(make_cmd(fba_pkg::FUNC_W'(u), $urandom, $urandom));
        end
        drive_command(make_cmd(fba_pkg::FN_REINIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // upper half free, the end wraps and is taken as memory size
        drive_command(make_cmd(fba_pkg::FN_REGION_FREE, 32'h0100_0000, 32'hFFFF_FFFF));

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            drive_command(random_cmd());
        end
        s_tvalid <= 1'b0;

        // drain the outstanding results, then watch for strays
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### frame_bitmap_allocator.f
hw/rtl/fba_pkg.sv
hw/rtl/fba_bitmap.sv
hw/rtl/frame_bitmap_allocator.sv
verif/tb_top.sv
